// ===== design/tmq_pkg.sv =====
// Shared types and constants of the timed message queue.
package tmq_pkg;

  localparam int unsigned QueueDepthDef  = 16;
  localparam int unsigned HandlerBitsDef = 16;

  localparam int unsigned ModeW    = 3;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned IdW      = 16;
  localparam int unsigned CodeW    = 32;
  localparam int unsigned TagW     = 16;
  localparam int unsigned PayloadW = 32;
  localparam int unsigned TimeW    = 64;

  typedef enum logic [ModeW-1:0] {
    MODE_ENQ     = 3'd0,
    MODE_POLL    = 3'd1,
    MODE_REM_H   = 3'd2,
    MODE_REM_HC  = 3'd3,
    MODE_REM_TAG = 3'd4
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 3'd0,
    ST_NULL      = 3'd1,
    ST_ZERO_TIME = 3'd2,
    ST_DUP       = 3'd3,
    ST_FULL      = 3'd4,
    ST_NONE      = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_INSERT,
    S_HEAD_CHK,
    S_CMP_RD,
    S_CMP_CHK,
    S_DONE
  } state_e;

  typedef struct packed {
    status_e              status;
    logic [IdW-1:0]       handler;
    logic [CodeW-1:0]     code;
    logic [TagW-1:0]      tag;
    logic [PayloadW-1:0]  payload;
    logic [TimeW-1:0]     etime;
  } result_t;

endpackage

// ===== design/tmq_if.sv =====
// Request and result channel interfaces of the timed message queue.
interface tmq_in_if import tmq_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [ModeW-1:0]           mode;
  logic [IdW-1:0]             handler_id;
  logic signed [CodeW-1:0]    what_code;
  logic [TagW-1:0]            msg_tag;
  logic [PayloadW-1:0]        msg_payload;
  logic [TimeW-1:0]           exec_time;
  logic [TimeW-1:0]           now_time;

  modport source (output valid, mode, handler_id, what_code, msg_tag, msg_payload,
                  exec_time, now_time, input ready);
  modport sink   (input valid, mode, handler_id, what_code, msg_tag, msg_payload,
                  exec_time, now_time, output ready);
endinterface

interface tmq_out_if import tmq_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [StatusW-1:0]         status;
  logic [IdW-1:0]             out_handler;
  logic signed [CodeW-1:0]    out_code;
  logic [TagW-1:0]            out_tag;
  logic [PayloadW-1:0]        out_payload;
  logic [TimeW-1:0]           out_time;

  modport source (output valid, status, out_handler, out_code, out_tag, out_payload,
                  out_time, input ready);
  modport sink   (input valid, status, out_handler, out_code, out_tag, out_payload,
                  out_time, output ready);
endinterface

// ===== design/timed_message_queue.sv =====
// Timed message queue: up to QueueDepth messages held in one entry memory, sorted by execution
// time with equal times in arrival order. One request is worked on at a time. Each step through
// the memory is a read followed by a check or a write back. The request channel reopens once the
// result sits in the output register, so the next request is taken while that result waits.
module timed_message_queue import tmq_pkg::*; #(
  parameter int unsigned QueueDepth  = QueueDepthDef,
  parameter int unsigned HandlerBits = HandlerBitsDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  tmq_in_if.sink   in_if,
  tmq_out_if.source out_if
);

  localparam int unsigned AddrW = $clog2(QueueDepth);
  localparam int unsigned CntW  = $clog2(QueueDepth + 1);

  typedef struct packed {
    logic [TimeW-1:0]       etime;
    logic [HandlerBits-1:0] handler;
    logic [CodeW-1:0]       code;
    logic [TagW-1:0]        tag;
    logic [PayloadW-1:0]    payload;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  state_e                 state_q, state_d;
  mode_e                  mode_q, mode_d;
  logic [HandlerBits-1:0] h_q, h_d;
  logic [CodeW-1:0]       code_q, code_d;
  logic [TagW-1:0]        tag_q, tag_d;
  logic [PayloadW-1:0]    pay_q, pay_d;
  logic [TimeW-1:0]       time_q, time_d;
  logic [TimeW-1:0]       now_q, now_d;
  logic [CntW-1:0]        count_q, count_d;
  logic [CntW-1:0]        idx_q, idx_d;
  logic [CntW-1:0]        wr_q, wr_d;
  logic [CntW-1:0]        pos_q, pos_d;
  logic                   found_q, found_d;
  result_t                res_q, res_d;
  result_t                out_q, out_d;
  logic                   out_valid_q, out_valid_d;

  logic                   we;
  logic [AddrW-1:0]       waddr, raddr;
  entry_t                 wdata, rdata;
  logic [EntryW-1:0]      rdata_raw;

  logic [HandlerBits+IdW-1:0] h_in_ext;
  logic [HandlerBits+IdW-1:0] h_out_ext;
  logic [HandlerBits-1:0]     h_in;
  logic [CntW-1:0]            idx_m1;
  logic                       hit;

  tmq_store #(
    .Depth (QueueDepth),
    .Width (EntryW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata_raw)
  );

  assign rdata = entry_t'(rdata_raw);

  // The handler is taken modulo 2^HandlerBits, and returned at the port width.
  assign h_in_ext  = {{HandlerBits{1'b0}}, in_if.handler_id};
  assign h_in      = h_in_ext[HandlerBits-1:0];
  assign h_out_ext = {{IdW{1'b0}}, rdata.handler};
  assign idx_m1    = idx_q - CntW'(1);

  always_comb begin
    case (mode_q)
      MODE_REM_H:   hit = (rdata.handler == h_q);
      MODE_REM_HC:  hit = (rdata.handler == h_q) && (rdata.code == code_q);
      MODE_REM_TAG: hit = (rdata.handler == h_q) && (rdata.tag == tag_q) && !found_q;
      default:      hit = 1'b0;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    h_d         = h_q;
    code_d      = code_q;
    tag_d       = tag_q;
    pay_d       = pay_q;
    time_d      = time_q;
    now_d       = now_q;
    count_d     = count_q;
    idx_d       = idx_q;
    wr_d        = wr_q;
    pos_d       = pos_q;
    found_d     = found_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_if.ready;
    we          = 1'b0;
    waddr       = '0;
    wdata       = '0;
    raddr       = '0;
    in_if.ready = (state_q == S_IDLE);

    case (state_q)
      S_IDLE: begin
        if (in_if.valid) begin
          mode_d  = mode_e'(in_if.mode);
          h_d     = h_in;
          code_d  = in_if.what_code;
          tag_d   = in_if.msg_tag;
          pay_d   = in_if.msg_payload;
          time_d  = in_if.exec_time;
          now_d   = in_if.now_time;
          idx_d   = '0;
          wr_d    = '0;
          pos_d   = count_q;
          found_d = 1'b0;
          res_d   = '0;
          res_d.status = ST_NONE;
          state_d = S_DONE;
          case (mode_e'(in_if.mode))
            MODE_ENQ: begin
              if (h_in == '0 || in_if.msg_tag == '0) begin
                res_d.status = ST_NULL;
              end else if (in_if.exec_time == '0) begin
                res_d.status = ST_ZERO_TIME;
              end else begin
                state_d = S_SCAN_RD;
              end
            end
            MODE_POLL: begin
              if (count_q != '0) begin
                state_d = S_HEAD_CHK;
              end
            end
            MODE_REM_H, MODE_REM_HC: begin
              if (h_in == '0) begin
                res_d.status = ST_NULL;
              end else begin
                state_d = S_CMP_RD;
              end
            end
            MODE_REM_TAG: begin
              if (h_in == '0 || in_if.msg_tag == '0) begin
                res_d.status = ST_NULL;
              end else begin
                state_d = S_CMP_RD;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_SCAN_RD: begin
        if (idx_q == count_q) begin
          if (found_q) begin
            res_d.status = ST_DUP;
            state_d      = S_DONE;
          end else if (count_q == CntW'(QueueDepth)) begin
            res_d.status = ST_FULL;
            state_d      = S_DONE;
          end else begin
            state_d = S_SHIFT_RD;
          end
        end else begin
          raddr   = idx_q[AddrW-1:0];
          state_d = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        // found_q marks a duplicate tag here; pos stays at count until a later time is seen.
        if (rdata.tag == tag_q) begin
          found_d = 1'b1;
        end
        if (pos_q == count_q && rdata.etime > time_q) begin
          pos_d = idx_q;
        end
        idx_d   = idx_q + CntW'(1);
        state_d = S_SCAN_RD;
      end
      S_SHIFT_RD: begin
        if (idx_q == pos_q) begin
          state_d = S_INSERT;
        end else begin
          raddr   = idx_m1[AddrW-1:0];
          state_d = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        we      = 1'b1;
        waddr   = idx_q[AddrW-1:0];
        wdata   = rdata;
        idx_d   = idx_m1;
        state_d = S_SHIFT_RD;
      end
      S_INSERT: begin
        we            = 1'b1;
        waddr         = pos_q[AddrW-1:0];
        wdata.etime   = time_q;
        wdata.handler = h_q;
        wdata.code    = code_q;
        wdata.tag     = tag_q;
        wdata.payload = pay_q;
        count_d       = count_q + CntW'(1);
        res_d.status  = ST_OK;
        state_d       = S_DONE;
      end
      S_HEAD_CHK: begin
        if (now_q >= rdata.etime) begin
          res_d.handler = h_out_ext[IdW-1:0];
          res_d.code    = rdata.code;
          res_d.tag     = rdata.tag;
          res_d.payload = rdata.payload;
          res_d.etime   = rdata.etime;
          found_d       = 1'b1;
          idx_d         = CntW'(1);
          state_d       = S_CMP_RD;
        end else begin
          state_d = S_DONE;
        end
      end
      S_CMP_RD: begin
        if (idx_q == count_q) begin
          count_d      = wr_q;
          res_d.status = found_q ? ST_OK : ST_NONE;
          state_d      = S_DONE;
        end else begin
          raddr   = idx_q[AddrW-1:0];
          state_d = S_CMP_CHK;
        end
      end
      S_CMP_CHK: begin
        // Kept entries move down to the write pointer, which never passes the read index.
        if (hit) begin
          found_d = 1'b1;
        end else begin
          we    = 1'b1;
          waddr = wr_q[AddrW-1:0];
          wdata = rdata;
          wr_d  = wr_q + CntW'(1);
        end
        idx_d   = idx_q + CntW'(1);
        state_d = S_CMP_RD;
      end
      S_DONE: begin
        if (!out_valid_q || out_if.ready) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q  <= mode_d;
    h_q     <= h_d;
    code_q  <= code_d;
    tag_q   <= tag_d;
    pay_q   <= pay_d;
    time_q  <= time_d;
    now_q   <= now_d;
    idx_q   <= idx_d;
    wr_q    <= wr_d;
    pos_q   <= pos_d;
    found_q <= found_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  assign out_if.valid       = out_valid_q;
  assign out_if.status      = out_q.status;
  assign out_if.out_handler = out_q.handler;
  assign out_if.out_code    = out_q.code;
  assign out_if.out_tag     = out_q.tag;
  assign out_if.out_payload = out_q.payload;
  assign out_if.out_time    = out_q.etime;

endmodule

// ===== design/tmq_store.sv =====
// Entry memory: one write port, one read port with registered read data.
module tmq_store #(
  parameter int unsigned Depth = 16,
  parameter int unsigned Width = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/tmq_checker.sv =====
// Port-level assertions for the timed message queue, bound to the top level.
module tmq_checker import tmq_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input logic [StatusW-1:0]  status_i,
  input logic [IdW-1:0]      handler_i,
  input logic [CodeW-1:0]    code_i,
  input logic [TagW-1:0]     tag_i,
  input logic [PayloadW-1:0] payload_i,
  input logic [TimeW-1:0]    time_i
);

  // A request keeps the block busy for at least the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request channel open right after a request was taken");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i) && $stable(time_i))
    else $error("stalled result changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> status_i <= StatusW'(ST_NONE))
    else $error("undefined status code");

  // Only a successful poll carries message fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != StatusW'(ST_OK) |->
      handler_i == '0 && code_i == '0 && tag_i == '0 && payload_i == '0 && time_i == '0)
    else $error("message fields set on a result that removed nothing");

endmodule

bind timed_message_queue tmq_checker u_tmq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .status_i    (out_if.status),
  .handler_i   (out_if.out_handler),
  .code_i      (out_if.out_code),
  .tag_i       (out_if.out_tag),
  .payload_i   (out_if.out_payload),
  .time_i      (out_if.out_time)
);

// ===== tb/tmq_checker.sv =====
// Checker of the timed message queue: predicts each result from the requests and compares it.
module tmq_scoreboard import tmq_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  tmq_in_if.sink  req_mon,
  tmq_out_if.sink res_mon,
  output int     fail_count,
  output int     pending_count,
  output int     queued_count
);

  localparam int unsigned Depth = QueueDepthDef;

  typedef struct packed {
    logic [TimeW-1:0]    etime;
    logic [IdW-1:0]      handler;
    logic [CodeW-1:0]    code;
    logic [TagW-1:0]     tag;
    logic [PayloadW-1:0] payload;
  } message_t;

  message_t msg_store [Depth];
  int       msg_count;
  result_t  expected_results [$];

  assign pending_count = expected_results.size();
  assign queued_count  = msg_count;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch in %s: got %0h, expected %0h", what, got, want);
    fail_count++;
  endtask

  // Deletes matching messages and closes the gaps; the tag mode removes only the first hit.
  function automatic bit purge_messages(input logic [ModeW-1:0] kind, input logic [IdW-1:0] h,
                                        input logic [CodeW-1:0] c, input logic [TagW-1:0] t);
    int  wr;
    bit  found;
    bit  hit;
    wr = 0;
    found = 0;
    for (int rd = 0; rd < msg_count; rd++) begin
      hit = msg_store[rd].handler == h;
      if (kind == MODE_REM_HC) hit = hit && msg_store[rd].code == c;
      else if (kind == MODE_REM_TAG) hit = hit && msg_store[rd].tag == t && !found;
      if (hit) found = 1;
      else begin
        msg_store[wr] = msg_store[rd];
        wr++;
      end
    end
    msg_count = wr;
    return found;
  endfunction

  function automatic result_t predict_result(input logic [ModeW-1:0] mode,
      input logic [IdW-1:0] h, input logic [CodeW-1:0] c, input logic [TagW-1:0] t,
      input logic [PayloadW-1:0] p, input logic [TimeW-1:0] et, input logic [TimeW-1:0] now);
    result_t r;
    int      pos;
    bit      dup;
    r = '0;
    r.status = ST_NONE;
    case (mode)
      MODE_ENQ: begin
        dup = 0;
        for (int i = 0; i < msg_count; i++) if (msg_store[i].tag == t) dup = 1;
        if (h == 0 || t == 0) r.status = ST_NULL;
        else if (et == 0) r.status = ST_ZERO_TIME;
        else if (dup) r.status = ST_DUP;
        else if (msg_count >= Depth) r.status = ST_FULL;
        else begin
          pos = 0;
          while (pos < msg_count && msg_store[pos].etime <= et) pos++;
          for (int i = msg_count; i > pos; i--) msg_store[i] = msg_store[i-1];
          msg_store[pos] = '{etime: et, handler: h, code: c, tag: t, payload: p};
          msg_count++;
          r.status = ST_OK;
        end
      end
      MODE_POLL: begin
        if (msg_count > 0 && now >= msg_store[0].etime) begin
          r.handler = msg_store[0].handler;
          r.code    = msg_store[0].code;
          r.tag     = msg_store[0].tag;
          r.payload = msg_store[0].payload;
          r.etime   = msg_store[0].etime;
          for (int i = 1; i < msg_count; i++) msg_store[i-1] = msg_store[i];
          msg_count--;
          r.status = ST_OK;
        end
      end
      MODE_REM_H, MODE_REM_HC: begin
        if (h == 0) r.status = ST_NULL;
        else r.status = purge_messages(mode, h, c, '0) ? ST_OK : ST_NONE;
      end
      MODE_REM_TAG: begin
        if (h == 0 || t == 0) r.status = ST_NULL;
        else r.status = purge_messages(mode, h, '0, t) ? ST_OK : ST_NONE;
      end
      default: r.status = ST_NONE;
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      msg_count <= 0;
      fail_count <= 0;
      expected_results.delete();
    end else begin
      if (res_mon.valid && res_mon.ready) begin
        if (expected_results.size() == 0) begin
          $display("result with no request outstanding");
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (res_mon.status != want.status)
            report_mismatch("status", res_mon.status, want.status);
          if (res_mon.out_handler != want.handler)
            report_mismatch("handler", res_mon.out_handler, want.handler);
          if (res_mon.out_code != want.code)
            report_mismatch("code", res_mon.out_code, want.code);
          if (res_mon.out_tag != want.tag)
            report_mismatch("tag", res_mon.out_tag, want.tag);
          if (res_mon.out_payload != want.payload)
            report_mismatch("payload", res_mon.out_payload, want.payload);
          if (res_mon.out_time != want.etime)
            report_mismatch("time", res_mon.out_time, want.etime);
        end
      end
      if (req_mon.valid && req_mon.ready)
        expected_results.push_back(predict_result(req_mon.mode, req_mon.handler_id,
            req_mon.what_code, req_mon.msg_tag, req_mon.msg_payload, req_mon.exec_time,
            req_mon.now_time));
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// Top of the timed message queue testbench: clock, reset, request stimulus and verdict.
module tb_top;
  import tmq_pkg::*;

  logic clk_i = 0;
  logic rst_ni = 0;
  int   fail_count;
  int   pending_count;
  int   queued_count;
  int   send_idle_pct = 10;
  int   recv_idle_pct = 51;
  bit   recv_hold = 0;
  logic [TimeW-1:0] clock_now = 100;
  logic [TagW-1:0]  next_tag = 1;

  tmq_in_if  req_if ();
  tmq_out_if res_if ();

  timed_message_queue i_dut (.clk_i(clk_i), .rst_ni(rst_ni), .in_if(req_if), .out_if(res_if));

  tmq_scoreboard i_checker (.clk_i(clk_i), .rst_ni(rst_ni), .req_mon(req_if), .res_mon(res_if),
                            .fail_count(fail_count), .pending_count(pending_count),
                            .queued_count(queued_count));

  always #5 clk_i = ~clk_i;

  // The receiver stalls at random, or for a long stretch while the hold flag is up.
  always @(posedge clk_i) begin
    if (recv_hold) res_if.ready <= 0;
    else res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // The request is held until ready is seen high between edges, so it is taken exactly once.
  task automatic send_request(input logic [ModeW-1:0] mode, input logic [IdW-1:0] h,
      input logic [CodeW-1:0] c, input logic [TagW-1:0] t, input logic [PayloadW-1:0] p,
      input logic [TimeW-1:0] et, input logic [TimeW-1:0] now);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 0;
      @(posedge clk_i);
    end
    req_if.valid <= 1;
    req_if.mode <= mode;
    req_if.handler_id <= h;
    req_if.what_code <= c;
    req_if.msg_tag <= t;
    req_if.msg_payload <= p;
    req_if.exec_time <= et;
    req_if.now_time <= now;
    @(negedge clk_i);
    while (!req_if.ready) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic drain_all();
    req_if.valid <= 0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  // Small handler and tag pools make duplicates, matches and full queues common.
  task automatic random_request();
    int          pick;
    logic [IdW-1:0] h;
    logic [TagW-1:0] t;
    logic [CodeW-1:0] c;
    logic [TimeW-1:0] et;
    pick = $urandom_range(99);
    h = ($urandom_range(9) == 0) ? IdW'($urandom) : IdW'($urandom_range(3));
    c = ($urandom_range(4) == 0) ? CodeW'($urandom) : CodeW'($urandom_range(2)) - 1;
    t = ($urandom_range(3) == 0) ? TagW'($urandom_range(20)) : next_tag;
    case ($urandom_range(5))
      0: et = 0;
      1: et = '1;
      2: et = {$urandom, $urandom};
      default: et = clock_now + $urandom_range(40);
    endcase
    if (pick < 45) begin
      send_request(MODE_ENQ, h, c, t, $urandom, et, '0);
      next_tag = next_tag + 1;
      if (next_tag == 0) next_tag = 1;
    end else if (pick < 75) begin
      clock_now = clock_now + $urandom_range(15);
      send_request(MODE_POLL, h, c, t, $urandom,
                   $urandom, ($urandom_range(19) == 0) ? '1 : clock_now);
    end else if (pick < 83) send_request(MODE_REM_H, h, c, t, $urandom, et, $urandom);
    else if (pick < 91) send_request(MODE_REM_HC, h, c, t, $urandom, et, $urandom);
    else if (pick < 98) send_request(MODE_REM_TAG, h, c, t, $urandom, et, $urandom);
    else send_request(ModeW'($urandom_range(7, 5)), h, c, t, $urandom, et, $urandom);
  endtask

  initial begin
    req_if.valid = 0;
    req_if.mode = '0;
    req_if.handler_id = '0;
    req_if.what_code = '0;
    req_if.msg_tag = '0;
    req_if.msg_payload = '0;
    req_if.exec_time = '0;
    req_if.now_time = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // Directed: every rejection but a full queue, equal times, extremes and every remove mode.
    send_request(MODE_POLL, 1, 0, 0, 0, 0, '1);
    send_request(MODE_ENQ, 0, 5, 7, 1, 10, 0);
    send_request(MODE_ENQ, 3, 5, 0, 1, 10, 0);
    send_request(MODE_ENQ, 3, 5, 7, 1, 0, 0);
    send_request(MODE_ENQ, 16'hffff, 32'h8000_0000, 16'hffff, 32'hffff_ffff, '1, 0);
    send_request(MODE_ENQ, 3, 32'h7fff_ffff, 7, 32'h1234, 10, 0);
    send_request(MODE_ENQ, 3, 5, 8, 2, 10, 0);
    send_request(MODE_ENQ, 4, 5, 7, 3, 20, 0);
    send_request(MODE_ENQ, 4, 6, 9, 4, 5, 0);
    send_request(MODE_POLL, 0, 0, 0, 0, 0, 4);
    send_request(MODE_POLL, 0, 0, 0, 0, 0, 10);
    send_request(MODE_REM_TAG, 0, 0, 8, 0, 0, 0);
    send_request(MODE_REM_TAG, 3, 0, 0, 0, 0, 0);
    send_request(MODE_REM_TAG, 4, 0, 8, 0, 0, 0);
    send_request(MODE_REM_TAG, 3, 0, 8, 0, 0, 0);
    send_request(MODE_REM_HC, 0, 5, 0, 0, 0, 0);
    send_request(MODE_REM_HC, 3, 6, 0, 0, 0, 0);
    send_request(MODE_REM_HC, 3, 32'h7fff_ffff, 0, 0, 0, 0);
    send_request(MODE_REM_H, 0, 0, 0, 0, 0, 0);
    send_request(MODE_REM_H, 16'hffff, 0, 0, 0, 0, 0);
    send_request(MODE_REM_H, 16'hffff, 0, 0, 0, 0, 0);
    send_request(3'd5, 1, 0, 0, 0, 0, 0);
    send_request(3'd7, 1, 0, 0, 0, 0, 0);
    send_request(MODE_POLL, 0, 0, 0, 0, 0, '1);
    send_request(MODE_POLL, 0, 0, 0, 0, 0, '1);
    next_tag = 100;
    // Fill past capacity while the receiver holds off, so that the input stalls.
    drain_all();
    recv_hold = 1;
    fork
      begin
        repeat (600) @(posedge clk_i);
        recv_hold = 0;
      end
      for (int i = 0; i < 18; i++) begin
        send_request(MODE_ENQ, 2, i, TagW'(200 + i), $urandom, 50 - i % 3, 0);
      end
    join
    drain_all();
    for (int i = 0; i < 1400; i++) begin
      if (i == 470) begin
        send_idle_pct = 51;
        recv_idle_pct = 10;
      end
      if (i == 940) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      random_request();
      if (i % 300 == 299) drain_all();
    end
    drain_all();
    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #20000000;
    $display("tb: failure");
    $finish;
  end

endmodule
